/* rtl/euler_totient_engine_unit_macros.svh */
// ---------------------------------------------------------------------------
// euler_totient_engine_unit assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// muted while reset is held.
// ---------------------------------------------------------------------------
`ifndef EULER_TOTIENT_ENGINE_UNIT_MACROS_SVH
`define EULER_TOTIENT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define ETE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("totient engine: same-cycle check failed");

// Next-cycle implication.
`define ETE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("totient engine: next-cycle check failed");

`endif

/* rtl/ete_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ete_pkg
// Widths and sequencer state codes for the Euler totient engine.
// ---------------------------------------------------------------------------
package ete_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIV_WIDTH   = 17;                 // odd trial divisor
  localparam int SQ_WIDTH    = 2 * DIV_WIDTH;      // divisor squared
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
  localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE  = SQ_WIDTH'(9);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVEN  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

/* rtl/euler_totient_engine_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_totient_engine_unit
// Euler totient of a 32-bit unsigned number by trial division.
// ---------------------------------------------------------------------------
// Pulse start with in_number while busy is low; the beat is taken on that
// edge and busy rises. When the work is done, out_valid is high for exactly
// one cycle with out_totient; there is no backpressure, so the receiver must
// take the beat in that cycle. busy falls on the cycle after the strobe.
// Processing time is data dependent and set by the bit-serial divider, which
// produces one quotient bit per cycle. Each odd candidate passes S_CHECK,
// a full division in S_DIV and S_EVAL; each prime factor found (with
// repeats) reruns S_DIV and S_EVAL before the same divisor is tried again.
// Zero is busy for a single cycle, the strobe cycle; a large prime near 2^32
// tries about 32768 candidates.
// ---------------------------------------------------------------------------
`include "euler_totient_engine_unit_macros.svh"

module euler_totient_engine_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ete_pkg::VALUE_WIDTH-1:0]  in_number,
  output logic                             out_valid,
  output logic [ete_pkg::VALUE_WIDTH-1:0]  out_totient
);

  localparam int VW = ete_pkg::VALUE_WIDTH;
  localparam int DW = ete_pkg::DIV_WIDTH;
  localparam int SW = ete_pkg::SQ_WIDTH;
  localparam int CW = ete_pkg::CNT_WIDTH;

  // Sequencer and working registers.
  ete_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;       // cofactor still to factor
  logic [VW-1:0]   prod_r, prod_nxt;     // running totient product
  logic [DW-1:0]   div_r, div_nxt;       // current odd trial divisor
  logic [SW-1:0]   sq_r, sq_nxt;         // div_r squared, kept by adds
  logic            found_r, found_nxt;   // div_r already divided rem once
  // Shared divider: dividend shifts out as quotient shifts in.
  logic [VW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   rmd_r, rmd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Divider step: one restoring subtract per cycle.
  logic [DW:0]     div_trial;
  logic            div_fits;
  logic [DW:0]     div_diff;
  assign div_trial = {rmd_r, quo_r[VW-1]};
  assign div_fits  = div_trial >= {1'b0, div_r};
  assign div_diff  = div_trial - {1'b0, div_r};

  // Shared multiplier: prod times (p-1), p or (rem-1); low half kept.
  logic [VW-1:0]   mul_b;
  logic [2*VW-1:0] mul_full;
  always_comb begin
    if (state_r == ete_pkg::S_LAST) begin
      mul_b = rem_r - VW'(1);
    end else if (found_r) begin
      mul_b = VW'(div_r);
    end else begin
      mul_b = VW'(div_r - DW'(1));
    end
  end
  assign mul_full = prod_r * mul_b;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    prod_nxt  = prod_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    found_nxt = found_r;
    quo_nxt   = quo_r;
    rmd_nxt   = rmd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ete_pkg::S_IDLE: begin
        if (start) begin
          div_nxt   = ete_pkg::FIRST_DIVISOR;
          sq_nxt    = ete_pkg::FIRST_SQUARE;
          found_nxt = 1'b0;
          prod_nxt  = VW'(1);
          if (in_number == '0) begin
            rem_nxt   = '0;
            div_nxt   = '0;
            prod_nxt  = '0;
            state_nxt = ete_pkg::S_DONE;
          end else if (!in_number[0]) begin
            // first factor of two contributes 1
            rem_nxt   = in_number >> 1;
            state_nxt = ete_pkg::S_EVEN;
          end else begin
            rem_nxt   = in_number;
            state_nxt = ete_pkg::S_CHECK;
          end
        end
      end
      ete_pkg::S_EVEN: begin
        if (!rem_r[0]) begin
          rem_nxt  = rem_r >> 1;
          prod_nxt = prod_r << 1;
        end else begin
          state_nxt = ete_pkg::S_CHECK;
        end
      end
      ete_pkg::S_CHECK: begin
        if (sq_r <= SW'(rem_r)) begin
          quo_nxt   = rem_r;
          rmd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ete_pkg::S_DIV;
        end else begin
          state_nxt = ete_pkg::S_LAST;
        end
      end
      ete_pkg::S_DIV: begin
        quo_nxt = {quo_r[VW-2:0], div_fits};
        rmd_nxt = div_fits ? div_diff[DW-1:0] : div_trial[DW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(VW - 1)) begin
          state_nxt = ete_pkg::S_EVAL;
        end
      end
      ete_pkg::S_EVAL: begin
        if (rmd_r == '0) begin
          // divides: take the factor and try the same divisor again
          rem_nxt   = quo_r;
          prod_nxt  = mul_full[VW-1:0];
          found_nxt = 1'b1;
          rmd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ete_pkg::S_DIV;
        end else begin
          div_nxt   = div_r + DW'(2);
          sq_nxt    = sq_r + SW'({div_r, 2'b00}) + SW'(4);
          found_nxt = 1'b0;
          state_nxt = ete_pkg::S_CHECK;
        end
      end
      ete_pkg::S_LAST: begin
        if (rem_r > VW'(1)) begin
          prod_nxt = mul_full[VW-1:0];
        end
        state_nxt = ete_pkg::S_DONE;
      end
      ete_pkg::S_DONE: begin
        state_nxt = ete_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ete_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ete_pkg::S_IDLE;
      rem_r   <= '0;
      prod_r  <= '0;
      div_r   <= '0;
      sq_r    <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      prod_r  <= prod_nxt;
      div_r   <= div_nxt;
      sq_r    <= sq_nxt;
      found_r <= found_nxt;
    end
  end

  // Divider datapath needs no reset.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rmd_r <= rmd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy        = (state_r != ete_pkg::S_IDLE);
  assign out_valid   = (state_r == ete_pkg::S_DONE);
  assign out_totient = prod_r;

  // Checks.
  `ETE_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ETE_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `ETE_ASSERT_SAME(a_rmd_below_div, clk, rst_n, state_r == ete_pkg::S_DIV, rmd_r < div_r)
  `ETE_ASSERT_SAME(a_odd_divisor, clk, rst_n, state_r == ete_pkg::S_CHECK, div_r[0])

endmodule
